// File: hw/rtl/cdq_pkg.sv
// shared codes, widths and types of the circular double-ended queue
`default_nettype none

package cdq_pkg;

   // operation codes of a request
   localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
   localparam logic [1:0] OP_PUSH_REAR  = 2'd1;
   localparam logic [1:0] OP_POP_FRONT  = 2'd2;
   localparam logic [1:0] OP_POP_REAR   = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_DONE       = 2'd0;
   localparam logic [1:0] STATUS_FULL       = 2'd1;
   localparam logic [1:0] STATUS_EMPTY      = 2'd2;

   // capacity register
   localparam int         CSR_W     = 5;
   localparam logic [4:0] CSR_RESET = 5'd16;

   // status flags that travel with a result
   typedef struct packed {
      logic [1:0] status;
      logic       is_empty;
      logic       is_full;
   } rsp_flags_type;

endpackage

`default_nettype wire

// File: hw/rtl/cdq_store.sv
// entry store: one write port, two registered read ports with write forwarding
`default_nettype none

module cdq_store #(
   parameter int MAX_DEPTH = 16,
   parameter int WORD_BITS = 32
) (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [$clog2(MAX_DEPTH)-1:0] wr_addr,
   input  wire logic [WORD_BITS-1:0]         wr_data,
   input  wire logic                         rd_en,
   input  wire logic [$clog2(MAX_DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(MAX_DEPTH)-1:0] rd_addr_b,
   output      logic [WORD_BITS-1:0]         rd_data_a,
   output      logic [WORD_BITS-1:0]         rd_data_b
);

   logic [WORD_BITS-1:0] mem_ff [MAX_DEPTH];
   logic [WORD_BITS-1:0] rd_a_ff;
   logic [WORD_BITS-1:0] rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read ports, a word written at the same edge is forwarded
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem_ff[rd_addr_a];
         rd_b_ff <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// File: hw/rtl/cdq_ctrl.sv
// head, tail and count update, capacity register and result flags
`default_nettype none

module cdq_ctrl #(
   parameter int MAX_DEPTH = 16,
   parameter int WORD_BITS = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire logic [1:0]                     operation,
   input  wire logic [WORD_BITS-1:0]           data_word,
   input  wire logic                           csr_write,
   input  wire logic [cdq_pkg::CSR_W-1:0]      csr_wdata,
   output      logic                           wr_en,
   output      logic [$clog2(MAX_DEPTH)-1:0]   wr_addr,
   output      logic [WORD_BITS-1:0]           wr_data,
   output      logic [$clog2(MAX_DEPTH)-1:0]   rd_addr_front,
   output      logic [$clog2(MAX_DEPTH)-1:0]   rd_addr_rear,
   output      logic                           rsp_valid,
   output      logic [$clog2(MAX_DEPTH+1)-1:0] fill_count,
   output      cdq_pkg::rsp_flags_type         flags
);

   localparam int IDX_W = $clog2(MAX_DEPTH);
   localparam int CNT_W = $clog2(MAX_DEPTH + 1);

   logic [cdq_pkg::CSR_W-1:0] cap_csr_ff;
   logic [IDX_W-1:0]          head_ff, head_in;
   logic [IDX_W-1:0]          tail_ff, tail_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      valid_ff;
   cdq_pkg::rsp_flags_type    flags_ff, flags_in;
   logic [CNT_W-1:0]          cap;
   logic [CNT_W-1:0]          head_inc, tail_inc;
   logic                      is_push;
   logic                      at_full;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_csr_ff <= cdq_pkg::CSR_RESET;
      end else if (csr_write) begin
         cap_csr_ff <= csr_wdata;
      end
   end

   // effective capacity, clamped to one through the store depth
   always_comb begin
      if (cap_csr_ff == '0) begin
         cap = CNT_W'(1);
      end else if (int'(cap_csr_ff) > MAX_DEPTH) begin
         cap = CNT_W'(MAX_DEPTH);
      end else begin
         cap = CNT_W'(cap_csr_ff);
      end
   end

   // index arithmetic with wrap at the capacity
   assign head_inc = CNT_W'(head_ff) + CNT_W'(1);
   assign tail_inc = CNT_W'(tail_ff) + CNT_W'(1);
   assign is_push  = !operation[1];
   assign at_full  = (count_ff >= cap);

   // next state for one request
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = '0;
      flags_in = flags_ff;
      if (accept) begin
         flags_in.status = cdq_pkg::STATUS_DONE;
         if (is_push) begin
            if (at_full) begin
               flags_in.status = cdq_pkg::STATUS_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               if (count_ff == '0) begin
                  head_in = '0;
                  tail_in = '0;
                  wr_addr = '0;
               end else if (operation == cdq_pkg::OP_PUSH_FRONT) begin
                  head_in = (head_ff == '0) ? IDX_W'(cap - CNT_W'(1)) : head_ff - IDX_W'(1);
                  wr_addr = head_in;
               end else begin
                  tail_in = (tail_inc >= cap) ? '0 : IDX_W'(tail_inc);
                  wr_addr = tail_in;
               end
            end
         end else begin
            if (count_ff == '0) begin
               flags_in.status = cdq_pkg::STATUS_EMPTY;
            end else if (count_ff == CNT_W'(1)) begin
               count_in = '0;
               head_in  = '0;
               tail_in  = '0;
            end else begin
               count_in = count_ff - CNT_W'(1);
               if (operation == cdq_pkg::OP_POP_FRONT) begin
                  head_in = (head_inc >= cap) ? '0 : IDX_W'(head_inc);
               end else begin
                  tail_in = (tail_ff == '0) ? IDX_W'(cap - CNT_W'(1)) : tail_ff - IDX_W'(1);
               end
            end
         end
         flags_in.is_empty = (count_in == '0);
         flags_in.is_full  = (count_in >= cap);
      end
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff <= flags_in;
   end

   assign wr_data       = data_word;
   assign rd_addr_front = head_in;
   assign rd_addr_rear  = tail_in;
   assign rsp_valid     = valid_ff;
   assign fill_count    = count_ff;
   assign flags         = flags_ff;

endmodule

`default_nettype wire

// File: hw/rtl/circular_double_ended_queue.sv
// top level of the circular double-ended queue
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-------------------------
//  request  | req_operation, req_data_word            | start high, busy low
//  result   | rsp_status, rsp_front_word, rsp_rear_word,
//           | rsp_fill_count, rsp_is_empty, rsp_is_full| rsp_valid, one cycle
//  config   | csr_wdata                               | csr_write
//
// one request per cycle; its result shows with rsp_valid in the next cycle.
// the entry store is written and read at the accept edge, a word written
// at that edge is forwarded to the read ports.
// reset clears head, tail and count and sets the capacity register to 16; the
// store keeps its contents and needs no clearing pass, so busy stays low.
// results cannot be stalled and each stands for exactly one cycle.
`default_nettype none

module circular_double_ended_queue #(
   parameter int MAX_DEPTH = 16,
   parameter int WORD_BITS = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output      logic                           busy,
   input  wire logic [1:0]                     req_operation,
   input  wire logic [WORD_BITS-1:0]           req_data_word,
   output      logic                           rsp_valid,
   output      logic [1:0]                     rsp_status,
   output      logic [WORD_BITS-1:0]           rsp_front_word,
   output      logic [WORD_BITS-1:0]           rsp_rear_word,
   output      logic [$clog2(MAX_DEPTH+1)-1:0] rsp_fill_count,
   output      logic                           rsp_is_empty,
   output      logic                           rsp_is_full,
   input  wire logic                           csr_write,
   input  wire logic [cdq_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int IDX_W = $clog2(MAX_DEPTH);

   logic                   accept;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [WORD_BITS-1:0]   wr_data;
   logic [IDX_W-1:0]       rd_addr_front;
   logic [IDX_W-1:0]       rd_addr_rear;
   logic [WORD_BITS-1:0]   rd_front;
   logic [WORD_BITS-1:0]   rd_rear;
   cdq_pkg::rsp_flags_type flags;

   // operations never stall, so busy is tied low
   assign busy   = 1'b0;
   assign accept = start && !busy;

   cdq_ctrl #(
      .MAX_DEPTH (MAX_DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .operation     (req_operation),
      .data_word     (req_data_word),
      .csr_write     (csr_write),
      .csr_wdata     (csr_wdata),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_addr_front (rd_addr_front),
      .rd_addr_rear  (rd_addr_rear),
      .rsp_valid     (rsp_valid),
      .fill_count    (rsp_fill_count),
      .flags         (flags)
   );

   cdq_store #(
      .MAX_DEPTH (MAX_DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (accept),
      .rd_addr_a (rd_addr_front),
      .rd_addr_b (rd_addr_rear),
      .rd_data_a (rd_front),
      .rd_data_b (rd_rear)
   );

   // words read as zero while the deque is empty
   assign rsp_front_word = flags.is_empty ? '0 : rd_front;
   assign rsp_rear_word  = flags.is_empty ? '0 : rd_rear;
   assign rsp_status     = flags.status;
   assign rsp_is_empty   = flags.is_empty;
   assign rsp_is_full    = flags.is_full;

endmodule

`default_nettype wire

// File: test/cdq_checker.sv
// response checker for the circular double-ended queue: predicts each response and compares it
module cdq_checker (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic                      busy,
   input  wire logic [1:0]                req_operation,
   input  wire logic [31:0]               req_data_word,
   input  wire logic                      rsp_valid,
   input  wire logic [1:0]                rsp_status,
   input  wire logic [31:0]               rsp_front_word,
   input  wire logic [31:0]               rsp_rear_word,
   input  wire logic [4:0]                rsp_fill_count,
   input  wire logic                      rsp_is_empty,
   input  wire logic                      rsp_is_full,
   input  wire logic                      csr_write,
   input  wire logic [cdq_pkg::CSR_W-1:0] csr_wdata,
   output int                             error_count,
   output int                             outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 16;

   // what the deque should report after one request
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] front_word;
      logic [31:0] rear_word;
      logic [4:0]  fill_count;
      logic        is_empty;
      logic        is_full;
   } deque_view_type;

   // shadow copy of the deque
   logic [3:0]                head_idx;
   logic [3:0]                tail_idx;
   logic [4:0]                entry_total;
   logic [cdq_pkg::CSR_W-1:0] capacity_reg;
   logic [31:0]               word_store [DEPTH];
   deque_view_type            pending_views [$];

   // apply one request to the shadow deque and return the view it should produce
   function automatic deque_view_type apply_operation(input logic [1:0] op,
                                                      input logic [31:0] word);
      int             cap;
      logic [3:0]     pos;
      deque_view_type view;
      // zero acts as one, anything past the depth as the depth
      if (capacity_reg == 0)
         cap = 1;
      else if (capacity_reg > DEPTH)
         cap = DEPTH;
      else
         cap = int'(capacity_reg);
      view.status = cdq_pkg::STATUS_DONE;
      if (op == cdq_pkg::OP_PUSH_FRONT || op == cdq_pkg::OP_PUSH_REAR) begin
         if (entry_total >= cap) begin
            view.status = cdq_pkg::STATUS_FULL;
         end else begin
            // a push into an empty deque restarts at entry zero
            if (entry_total == 0) begin
               head_idx = '0;
               tail_idx = '0;
            end else if (op == cdq_pkg::OP_PUSH_FRONT) begin
               head_idx = (head_idx == 0) ? 4'(cap - 1) : head_idx - 4'd1;
            end else begin
               tail_idx = (tail_idx + 1 >= cap) ? 4'd0 : tail_idx + 4'd1;
            end
            pos = (op == cdq_pkg::OP_PUSH_FRONT) ? head_idx : tail_idx;
            word_store[pos] = word;
            entry_total = entry_total + 5'd1;
         end
      end else if (entry_total == 0) begin
         view.status = cdq_pkg::STATUS_EMPTY;
      end else if (entry_total == 1) begin
         // last entry gone, indices return to zero
         entry_total = '0;
         head_idx    = '0;
         tail_idx    = '0;
      end else begin
         if (op == cdq_pkg::OP_POP_FRONT)
            head_idx = (head_idx + 1 >= cap) ? 4'd0 : head_idx + 4'd1;
         else
            tail_idx = (tail_idx == 0) ? 4'(cap - 1) : tail_idx - 4'd1;
         entry_total = entry_total - 5'd1;
      end
      view.front_word = (entry_total != 0) ? word_store[head_idx] : '0;
      view.rear_word  = (entry_total != 0) ? word_store[tail_idx] : '0;
      view.fill_count = entry_total;
      view.is_empty   = (entry_total == 0);
      view.is_full    = (entry_total >= cap);
      return view;
   endfunction

   // compare responses, then track requests and capacity writes
   always @(posedge clock) begin
      deque_view_type want;
      if (reset) begin
         head_idx     = '0;
         tail_idx     = '0;
         entry_total  = '0;
         capacity_reg = cdq_pkg::CSR_RESET;
         pending_views.delete();
      end else begin
         // response standing in this cycle
         if (rsp_valid) begin
            if (pending_views.size() == 0) begin
               if (error_count < 10)
                  $display("%0t: response with no request waiting", $realtime);
               error_count++;
            end else begin
               want = pending_views.pop_front();
               if (rsp_status !== want.status || rsp_front_word !== want.front_word ||
                   rsp_rear_word !== want.rear_word || rsp_fill_count !== want.fill_count ||
                   rsp_is_empty !== want.is_empty || rsp_is_full !== want.is_full) begin
                  if (error_count < 10)
                     $display({"%0t: mismatch (expected/actual) status %0d/%0d front %h/%h",
                               " rear %h/%h fill %0d/%0d empty %b/%b full %b/%b"},
                              $realtime, want.status, rsp_status,
                              want.front_word, rsp_front_word,
                              want.rear_word, rsp_rear_word,
                              want.fill_count, rsp_fill_count,
                              want.is_empty, rsp_is_empty,
                              want.is_full, rsp_is_full);
                  error_count++;
               end
            end
         end
         // accepted request
         if (start && !busy)
            pending_views.push_back(apply_operation(req_operation, req_data_word));
         // capacity write
         if (csr_write)
            capacity_reg = csr_wdata;
      end
      outstanding = pending_views.size();
   end

endmodule

// File: test/circular_double_ended_queue_tb.sv
// testbench top for the circular double-ended queue: stimulus, watchdog and verdict
module circular_double_ended_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT   = 1000;
   localparam int RANDOM_PER_PHASE = 510;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [1:0]                req_operation;
   logic [31:0]               req_data_word;
   logic                      rsp_valid;
   logic [1:0]                rsp_status;
   logic [31:0]               rsp_front_word;
   logic [31:0]               rsp_rear_word;
   logic [4:0]                rsp_fill_count;
   logic                      rsp_is_empty;
   logic                      rsp_is_full;
   logic                      csr_write;
   logic [cdq_pkg::CSR_W-1:0] csr_wdata;

   int error_count;
   int outstanding;
   int sender_idle_pct;
   int quiet_cycles = 0;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   circular_double_ended_queue uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_data_word  (req_data_word),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_front_word (rsp_front_word),
      .rsp_rear_word  (rsp_rear_word),
      .rsp_fill_count (rsp_fill_count),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full),
      .csr_write      (csr_write),
      .csr_wdata      (csr_wdata)
   );

   cdq_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_data_word  (req_data_word),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_front_word (rsp_front_word),
      .rsp_rear_word  (rsp_rear_word),
      .rsp_fill_count (rsp_fill_count),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full),
      .csr_write      (csr_write),
      .csr_wdata      (csr_wdata),
      .error_count    (error_count),
      .outstanding    (outstanding)
   );

   // one request, with random idle cycles ahead of it
   task automatic send_request(input logic [1:0] op, input logic [31:0] word);
      while ($urandom_range(99) < sender_idle_pct) begin
         start         <= 1'b0;
         req_operation <= 2'($urandom_range(3));
         req_data_word <= $urandom;
         @(negedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_data_word <= word;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // capacity write once every response is in
   task automatic write_capacity(input logic [cdq_pkg::CSR_W-1:0] value);
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // bursts of requests, each under a fresh capacity and a fill or drain bias
   task automatic run_random(input int count);
      int                        issued;
      int                        push_pct;
      int                        burst;
      int                        roll;
      logic [1:0]                op;
      logic [31:0]               word;
      logic [cdq_pkg::CSR_W-1:0] cap;
      issued = 0;
      while (issued < count) begin
         // extremes of the capacity come up often
         case ($urandom_range(9))
            0:       cap = 5'd0;
            1:       cap = 5'd1;
            2:       cap = 5'd16;
            3:       cap = 5'd17;
            4:       cap = 5'd31;
            default: cap = 5'($urandom_range(31));
         endcase
         write_capacity(cap);
         case ($urandom_range(2))
            0:       push_pct = 75;
            1:       push_pct = 25;
            default: push_pct = 50;
         endcase
         burst = $urandom_range(60, 12);
         repeat (burst) begin
            roll  = $urandom_range(99);
            op[1] = (roll >= push_pct);
            op[0] = 1'($urandom_range(1));
            case ($urandom_range(15))
               0:       word = '0;
               1:       word = '1;
               default: word = $urandom;
            endcase
            send_request(op, word);
            issued++;
         end
      end
   endtask

   // watchdog on cycles with no request or response accepted
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT - 1) begin
         $display("circular_double_ended_queue_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus and verdict
   initial begin
      int k;
      reset           = 1'b1;
      start           = 1'b0;
      req_operation   = cdq_pkg::OP_PUSH_FRONT;
      req_data_word   = '0;
      csr_write       = 1'b0;
      csr_wdata       = '0;
      sender_idle_pct = 16;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // pops from an empty deque are rejected
      send_request(cdq_pkg::OP_POP_FRONT, 32'hFFFF_FFFF);
      send_request(cdq_pkg::OP_POP_REAR, 32'h0);
      // fill every store entry at full capacity
      send_request(cdq_pkg::OP_PUSH_REAR, 32'h0);
      send_request(cdq_pkg::OP_PUSH_REAR, 32'hFFFF_FFFF);
      for (k = 2; k < 16; k++)
         send_request(cdq_pkg::OP_PUSH_REAR, $urandom);
      // pushes into a full deque are rejected
      send_request(cdq_pkg::OP_PUSH_FRONT, 32'hA5A5_A5A5);
      send_request(cdq_pkg::OP_PUSH_REAR, 32'h5A5A_5A5A);
      // head walks back across the wrap point
      send_request(cdq_pkg::OP_POP_REAR, 32'h0);
      send_request(cdq_pkg::OP_POP_FRONT, 32'h0);
      send_request(cdq_pkg::OP_PUSH_FRONT, $urandom);
      send_request(cdq_pkg::OP_POP_REAR, 32'h0);
      send_request(cdq_pkg::OP_PUSH_FRONT, $urandom);
      // capacity lowered below the fill count: full, pushes rejected, pops wrap
      write_capacity(5'd4);
      send_request(cdq_pkg::OP_PUSH_REAR, $urandom);
      send_request(cdq_pkg::OP_POP_FRONT, 32'h0);
      send_request(cdq_pkg::OP_POP_REAR, 32'h0);

      // random phases with the sender idling less, more, then not at all
      sender_idle_pct = 16;
      run_random(RANDOM_PER_PHASE);
      sender_idle_pct = 78;
      run_random(RANDOM_PER_PHASE);
      sender_idle_pct = 0;
      run_random(RANDOM_PER_PHASE);

      // drain and settle
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (4) @(negedge clock);
      if (error_count == 0 && outstanding == 0)
         $display("circular_double_ended_queue_tb: clean");
      else
         $display("circular_double_ended_queue_tb: errors");
      $finish;
   end

endmodule
